// ===== hdl/psh_pkg.sv =====
// constants, microcode types and program rom for the polynomial surface height evaluator
package psh_pkg;

  localparam int MAX_ORDER   = 8;
  localparam int SCALE_SHIFT = 8;
  localparam int TABLE_DEPTH = 3 * MAX_ORDER + 5;
  localparam int ZMIN_SLOT   = 3 * MAX_ORDER + 3;
  localparam int ZMAX_SLOT   = 3 * MAX_ORDER + 4;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int ORD_W       = $clog2(MAX_ORDER + 1);

  localparam int IDX_W      = 5;
  localparam int WORD_W     = 48;
  localparam int COORD_W    = 32;
  localparam int FRAC_W     = 16;
  localparam int HALF_W     = WORD_W / 2;
  localparam int PROD_W     = 2 * WORD_W;
  localparam int DIFF_W     = WORD_W + 1;
  localparam int ZACC_W     = WORD_W + 1 + $clog2(3 * MAX_ORDER + 1);
  localparam int SQ_W       = 64;
  localparam int IN_DATA_W  = 120;
  localparam int OUT_DATA_W = 96;

  localparam logic signed [WORD_W-1:0] ONE_Q16 = WORD_W'(65536);

  localparam int PROG_LEN = 27;
  localparam int PC_W     = $clog2(PROG_LEN);
  localparam int LOOP_PC  = 13;

  typedef enum logic [4:0] {
    OP_NOP,
    OP_LD_U,
    OP_LD_V,
    OP_LD_Z,
    OP_LD_LO,
    OP_LD_HI,
    OP_M_UU,
    OP_M_VV,
    OP_M_PU,
    OP_M_PV,
    OP_M_PR,
    OP_M_TA,
    OP_M_TB,
    OP_M_TC,
    OP_CAP_SQ,
    OP_ADD_SQ,
    OP_SQ_INIT,
    OP_SQ_STEP,
    OP_LD_RHO,
    OP_CAP_PU,
    OP_CAP_PV,
    OP_CAP_PR,
    OP_ADD_Z,
    OP_INC_I,
    OP_FIN
  } op_t;

  typedef enum logic [2:0] {
    RD_X0,
    RD_Y0,
    RD_Z0,
    RD_ZMIN,
    RD_ZMAX,
    RD_A,
    RD_B,
    RD_C
  } rd_t;

  typedef enum logic [2:0] {
    C_NEXT,
    C_WAIT_MUL,
    C_WAIT_SQRT,
    C_WAIT_OUT,
    C_LOOP
  } cond_t;

  typedef struct packed {
    op_t             op;
    rd_t             rd;
    cond_t           cond;
    logic [PC_W-1:0] tgt;
    logic            last;
  } ucode_t;

  function automatic ucode_t step(op_t op, rd_t rd, cond_t cond, int tgt, logic last);
    ucode_t w;
    w.op   = op;
    w.rd   = rd;
    w.cond = cond;
    w.tgt  = PC_W'(tgt);
    w.last = last;
    return w;
  endfunction

  function automatic logic signed [COORD_W-1:0] sat32(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sh0000_0000_7FFF_FFFF;
    lo = -hi - 64'sd1;
    if (v > hi) return hi[COORD_W-1:0];
    if (v < lo) return lo[COORD_W-1:0];
    return v[COORD_W-1:0];
  endfunction

  localparam ucode_t PROGRAM [PROG_LEN] = '{
    step(OP_NOP,     RD_X0,   C_NEXT,      0,       1'b0),
    step(OP_LD_U,    RD_Y0,   C_NEXT,      0,       1'b0),
    step(OP_LD_V,    RD_Z0,   C_NEXT,      0,       1'b0),
    step(OP_LD_Z,    RD_ZMIN, C_NEXT,      0,       1'b0),
    step(OP_LD_LO,   RD_ZMAX, C_NEXT,      0,       1'b0),
    step(OP_LD_HI,   RD_X0,   C_NEXT,      0,       1'b0),
    step(OP_M_UU,    RD_X0,   C_NEXT,      0,       1'b0),
    step(OP_CAP_SQ,  RD_X0,   C_WAIT_MUL,  0,       1'b0),
    step(OP_M_VV,    RD_X0,   C_NEXT,      0,       1'b0),
    step(OP_ADD_SQ,  RD_X0,   C_WAIT_MUL,  0,       1'b0),
    step(OP_SQ_INIT, RD_X0,   C_NEXT,      0,       1'b0),
    step(OP_SQ_STEP, RD_X0,   C_WAIT_SQRT, 0,       1'b0),
    step(OP_LD_RHO,  RD_X0,   C_NEXT,      0,       1'b0),
    step(OP_M_PU,    RD_X0,   C_NEXT,      0,       1'b0),
    step(OP_CAP_PU,  RD_A,    C_WAIT_MUL,  0,       1'b0),
    step(OP_M_TA,    RD_X0,   C_NEXT,      0,       1'b0),
    step(OP_ADD_Z,   RD_X0,   C_WAIT_MUL,  0,       1'b0),
    step(OP_M_PV,    RD_X0,   C_NEXT,      0,       1'b0),
    step(OP_CAP_PV,  RD_B,    C_WAIT_MUL,  0,       1'b0),
    step(OP_M_TB,    RD_X0,   C_NEXT,      0,       1'b0),
    step(OP_ADD_Z,   RD_X0,   C_WAIT_MUL,  0,       1'b0),
    step(OP_M_PR,    RD_X0,   C_NEXT,      0,       1'b0),
    step(OP_CAP_PR,  RD_C,    C_WAIT_MUL,  0,       1'b0),
    step(OP_M_TC,    RD_X0,   C_NEXT,      0,       1'b0),
    step(OP_ADD_Z,   RD_X0,   C_WAIT_MUL,  0,       1'b0),
    step(OP_INC_I,   RD_X0,   C_LOOP,      LOOP_PC, 1'b0),
    step(OP_FIN,     RD_X0,   C_WAIT_OUT,  0,       1'b1)
  };

endpackage

// ===== hdl/poly_surface_height_eval.sv =====
// top level: coefficient table, microcoded sequencer and datapath of the surface evaluator
//
//   channel  dir  transfer carries
//   s_*      in   write command (tuser 0) or evaluate command (tuser 1) with its point
//   m_*      out  x, y echo and clamped height z, one per evaluate command
//
// an evaluation's length is set by the 50 products that all pass through one 24x24
// multiplier, plus 32 steps of the square root
// rst clears the sequencer, the output valid and the table valid bits (table reads zero)
// s_tready drops during an evaluation; a held result stalls the last step only
module poly_surface_height_eval (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // coef_index, coef_value, x_coord, y_coord, zero pad
  input  logic [psh_pkg::IN_DATA_W-1:0]     s_tdata,
  // command
  input  logic [0:0]                        s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // x_out, y_out, z_out
  output logic [psh_pkg::OUT_DATA_W-1:0]    m_tdata
);

  localparam int AW = psh_pkg::ADDR_W;
  localparam int WW = psh_pkg::WORD_W;
  localparam int CW = psh_pkg::COORD_W;

  logic [psh_pkg::WORD_W-1:0]       mem [psh_pkg::TABLE_DEPTH];
  logic [psh_pkg::TABLE_DEPTH-1:0]  vld;

  logic                             busy;
  logic [psh_pkg::PC_W-1:0]         pc;
  logic [psh_pkg::PC_W-1:0]         pc_next;
  psh_pkg::ucode_t                  cw;
  logic                             stay;
  logic                             jump;
  logic                             out_full;
  logic                             fin_fire;
  logic                             s_xfer;

  logic [psh_pkg::IDX_W-1:0]        in_index;
  logic signed [WW-1:0]             in_value;
  logic signed [CW-1:0]             in_x;
  logic signed [CW-1:0]             in_y;

  logic signed [CW-1:0]             x;
  logic signed [CW-1:0]             y;
  logic signed [CW-1:0]             u;
  logic signed [CW-1:0]             v;
  logic signed [WW-1:0]             rho;
  logic signed [WW-1:0]             pu;
  logic signed [WW-1:0]             pv;
  logic signed [WW-1:0]             pr;
  logic signed [psh_pkg::ZACC_W-1:0] z;
  logic signed [CW-1:0]             zlo;
  logic signed [CW-1:0]             zhi;
  logic [psh_pkg::ORD_W-1:0]        ord;
  logic [psh_pkg::SQ_W-1:0]         sq_n;
  logic [psh_pkg::SQ_W-1:0]         sq_res;
  logic [psh_pkg::SQ_W-1:0]         sq_bit;
  logic [psh_pkg::SQ_W-1:0]         sq_t;
  logic signed [WW-1:0]             rdata;

  logic [AW-1:0]                    rd_addr;
  logic [AW-1:0]                    ord3;
  logic [AW-1:0]                    wr_addr;

  logic signed [psh_pkg::DIFF_W-1:0] du;
  logic signed [psh_pkg::DIFF_W-1:0] dv;
  logic signed [CW-1:0]             u_new;
  logic signed [CW-1:0]             v_new;

  logic                             mul_start;
  logic                             mul_done;
  logic [psh_pkg::PROD_W-1:0]       prod;
  logic signed [WW-1:0]             op_a;
  logic signed [WW-1:0]             op_b;
  logic [WW-1:0]                    a_mag;
  logic [WW-1:0]                    b_mag;
  logic                             neg;
  logic [psh_pkg::PROD_W-psh_pkg::FRAC_W-1:0] q_r;
  logic [psh_pkg::PROD_W-psh_pkg::FRAC_W-1:0] q_lim;
  logic [WW-1:0]                    q_mag;
  logic signed [WW-1:0]             qval;

  logic signed [CW-1:0]             z_sat;
  logic signed [CW-1:0]             z_lo;
  logic signed [CW-1:0]             z_fin;

  assign in_index = s_tdata[psh_pkg::IDX_W-1:0];
  assign in_value = s_tdata[psh_pkg::IDX_W+WW-1:psh_pkg::IDX_W];
  assign in_x     = s_tdata[psh_pkg::IDX_W+WW+CW-1:psh_pkg::IDX_W+WW];
  assign in_y     = s_tdata[psh_pkg::IDX_W+WW+2*CW-1:psh_pkg::IDX_W+WW+CW];

  assign s_tready = !busy;
  assign s_xfer   = s_tvalid && s_tready;
  assign wr_addr  = AW'(in_index);
  assign cw       = psh_pkg::PROGRAM[pc];
  assign out_full = m_tvalid && !m_tready;
  assign fin_fire = busy && (cw.op == psh_pkg::OP_FIN) && !out_full;

  // sequencer
  always_comb begin
    stay = 1'b0;
    jump = 1'b0;
    case (cw.cond)
      psh_pkg::C_WAIT_MUL:  stay = !mul_done;
      psh_pkg::C_WAIT_SQRT: stay = !sq_bit[0];
      psh_pkg::C_WAIT_OUT:  stay = out_full;
      psh_pkg::C_LOOP:      jump = (ord != psh_pkg::ORD_W'(psh_pkg::MAX_ORDER));
      default:              ;
    endcase
    if (stay)      pc_next = pc;
    else if (jump) pc_next = cw.tgt;
    else           pc_next = pc + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      pc       <= '0;
      m_tvalid <= 1'b0;
      vld      <= '0;
    end else begin
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      if (!busy) begin
        pc <= '0;
        if (s_xfer && s_tuser[0]) busy <= 1'b1;
        if (s_xfer && !s_tuser[0] && int'(in_index) < psh_pkg::TABLE_DEPTH) begin
          vld[wr_addr] <= 1'b1;
        end
      end else begin
        pc <= pc_next;
        if (fin_fire) m_tvalid <= 1'b1;
        if (cw.last && !stay) begin
          busy <= 1'b0;
          pc   <= '0;
        end
      end
    end
  end

  // coefficient table
  always_comb begin
    ord3 = (AW'(ord) << 1) + AW'(ord);
    case (cw.rd)
      psh_pkg::RD_Y0:   rd_addr = AW'(1);
      psh_pkg::RD_Z0:   rd_addr = AW'(2);
      psh_pkg::RD_ZMIN: rd_addr = AW'(psh_pkg::ZMIN_SLOT);
      psh_pkg::RD_ZMAX: rd_addr = AW'(psh_pkg::ZMAX_SLOT);
      psh_pkg::RD_A:    rd_addr = ord3;
      psh_pkg::RD_B:    rd_addr = ord3 + AW'(1);
      psh_pkg::RD_C:    rd_addr = ord3 + AW'(2);
      default:          rd_addr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (s_xfer && !s_tuser[0] && int'(in_index) < psh_pkg::TABLE_DEPTH) begin
      mem[wr_addr] <= in_value;
    end
    rdata <= vld[rd_addr] ? mem[rd_addr] : '0;
  end

  // multiplier operands and q16 product with saturation
  always_comb begin
    case (cw.op)
      psh_pkg::OP_M_UU: begin op_a = WW'(u);   op_b = WW'(u);   end
      psh_pkg::OP_M_VV: begin op_a = WW'(v);   op_b = WW'(v);   end
      psh_pkg::OP_M_PU: begin op_a = pu;       op_b = WW'(u);   end
      psh_pkg::OP_M_PV: begin op_a = pv;       op_b = WW'(v);   end
      psh_pkg::OP_M_PR: begin op_a = pr;       op_b = rho;      end
      psh_pkg::OP_M_TA: begin op_a = rdata;    op_b = pu;       end
      psh_pkg::OP_M_TB: begin op_a = rdata;    op_b = pv;       end
      psh_pkg::OP_M_TC: begin op_a = rdata;    op_b = pr;       end
      default:          begin op_a = '0;       op_b = '0;       end
    endcase
  end

  assign mul_start = busy && (cw.op == psh_pkg::OP_M_UU || cw.op == psh_pkg::OP_M_VV ||
                              cw.op == psh_pkg::OP_M_PU || cw.op == psh_pkg::OP_M_PV ||
                              cw.op == psh_pkg::OP_M_PR || cw.op == psh_pkg::OP_M_TA ||
                              cw.op == psh_pkg::OP_M_TB || cw.op == psh_pkg::OP_M_TC);
  assign a_mag = op_a[WW-1] ? -op_a : op_a;
  assign b_mag = op_b[WW-1] ? -op_b : op_b;

  psh_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a_mag (a_mag),
    .b_mag (b_mag),
    .done  (mul_done),
    .prod  (prod)
  );

  always_comb begin
    q_r   = prod[psh_pkg::PROD_W-1:psh_pkg::FRAC_W];
    q_lim = neg ? ($bits(q_r))'(1) << (WW - 1) : (($bits(q_r))'(1) << (WW - 1)) - 1'b1;
    q_mag = (q_r > q_lim) ? q_lim[WW-1:0] : q_r[WW-1:0];
    qval  = neg ? -q_mag : q_mag;
  end

  // point offset, square root step and clamp
  assign du    = psh_pkg::DIFF_W'(x) - psh_pkg::DIFF_W'(rdata);
  assign dv    = psh_pkg::DIFF_W'(y) - psh_pkg::DIFF_W'(rdata);
  assign u_new = psh_pkg::sat32(64'(du >>> psh_pkg::SCALE_SHIFT));
  assign v_new = psh_pkg::sat32(64'(dv >>> psh_pkg::SCALE_SHIFT));
  assign sq_t  = sq_res + sq_bit;

  assign z_sat = psh_pkg::sat32(64'(z));
  assign z_lo  = (z_sat < zlo) ? zlo : z_sat;
  assign z_fin = (z_lo > zhi) ? zhi : z_lo;

  always_ff @(posedge clk) begin
    if (!busy && s_xfer && s_tuser[0]) begin
      x <= in_x;
      y <= in_y;
    end
    if (mul_start) neg <= op_a[WW-1] ^ op_b[WW-1];
    if (fin_fire) m_tdata <= {z_fin, y, x};
    if (busy) begin
      case (cw.op)
        psh_pkg::OP_LD_U:    u <= u_new;
        psh_pkg::OP_LD_V:    v <= v_new;
        psh_pkg::OP_LD_Z: begin
          z   <= psh_pkg::ZACC_W'(rdata);
          pu  <= psh_pkg::ONE_Q16;
          pv  <= psh_pkg::ONE_Q16;
          pr  <= psh_pkg::ONE_Q16;
          ord <= psh_pkg::ORD_W'(1);
        end
        psh_pkg::OP_LD_LO:   zlo <= psh_pkg::sat32(64'(rdata));
        psh_pkg::OP_LD_HI:   zhi <= psh_pkg::sat32(64'(rdata));
        psh_pkg::OP_CAP_SQ:  if (mul_done) sq_n <= prod[psh_pkg::SQ_W-1:0];
        psh_pkg::OP_ADD_SQ:  if (mul_done) sq_n <= sq_n + prod[psh_pkg::SQ_W-1:0];
        psh_pkg::OP_SQ_INIT: begin
          sq_res <= '0;
          sq_bit <= psh_pkg::SQ_W'(1) << (psh_pkg::SQ_W - 2);
        end
        psh_pkg::OP_SQ_STEP: begin
          if (sq_n >= sq_t) begin
            sq_n   <= sq_n - sq_t;
            sq_res <= (sq_res >> 1) + sq_bit;
          end else begin
            sq_res <= sq_res >> 1;
          end
          sq_bit <= sq_bit >> 2;
        end
        psh_pkg::OP_LD_RHO:  rho <= WW'(sq_res[psh_pkg::SQ_W/2-1:0]);
        psh_pkg::OP_CAP_PU:  if (mul_done) pu <= qval;
        psh_pkg::OP_CAP_PV:  if (mul_done) pv <= qval;
        psh_pkg::OP_CAP_PR:  if (mul_done) pr <= qval;
        psh_pkg::OP_ADD_Z:   if (mul_done) z <= z + psh_pkg::ZACC_W'(qval);
        psh_pkg::OP_INC_I:   ord <= ord + 1'b1;
        default:             ;
      endcase
    end
  end

endmodule

// ===== hdl/psh_mul.sv =====
// iterative unsigned multiplier, four half-width partial products formed one at a time
module psh_mul (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [psh_pkg::WORD_W-1:0]    a_mag,
  input  logic [psh_pkg::WORD_W-1:0]    b_mag,
  output logic                          done,
  output logic [psh_pkg::PROD_W-1:0]    prod
);

  logic                          active;
  logic [2:0]                    ph;
  logic [psh_pkg::WORD_W-1:0]    a_q;
  logic [psh_pkg::WORD_W-1:0]    b_q;
  logic [psh_pkg::HALF_W-1:0]    op_a;
  logic [psh_pkg::HALF_W-1:0]    op_b;
  logic [2*psh_pkg::HALF_W-1:0]  pp;
  logic [2*psh_pkg::HALF_W-1:0]  pp_next;
  logic [psh_pkg::PROD_W-1:0]    addend;

  assign op_a    = ph[1] ? a_q[psh_pkg::WORD_W-1:psh_pkg::HALF_W] : a_q[psh_pkg::HALF_W-1:0];
  assign op_b    = ph[0] ? b_q[psh_pkg::WORD_W-1:psh_pkg::HALF_W] : b_q[psh_pkg::HALF_W-1:0];
  assign pp_next = op_a * op_b;

  // weight of the partial product formed in the previous phase
  always_comb begin
    case (ph)
      3'd1:    addend = psh_pkg::PROD_W'(pp);
      3'd4:    addend = psh_pkg::PROD_W'(pp) << (2 * psh_pkg::HALF_W);
      default: addend = psh_pkg::PROD_W'(pp) << psh_pkg::HALF_W;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      ph     <= 3'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        ph     <= 3'd0;
      end else if (active) begin
        ph <= ph + 3'd1;
        if (ph == 3'd4) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_q  <= a_mag;
      b_q  <= b_mag;
      prod <= '0;
    end else if (active) begin
      pp <= pp_next;
      if (ph != 3'd0) prod <= prod + addend;
    end
  end

endmodule
